// ===== design/rgb_led_pwm_with_hsv_macros.svh =====
// ----------------------------------------------------------------------------
// rgb_led_pwm_with_hsv_macros.svh - assertion macros
// Clocked assertion helpers for the RGB PWM block. All of them sample on
// aclk and are disabled while aresetn is low. Define NO_ASSERTIONS to drop
// them.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_PWM_WITH_HSV_MACROS_SVH
`define RGB_LED_PWM_WITH_HSV_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent and consequent in the same cycle.
`define RLPH_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("assertion failed: same-cycle check");

// Consequent in the cycle after the antecedent.
`define RLPH_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("assertion failed: next-cycle check");

`else

`define RLPH_ASSERT_SAME(name, ante, cons)
`define RLPH_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== design/rlph_pkg.sv =====
// ----------------------------------------------------------------------------
// rlph_pkg - shared types and constants
// Item kinds, configuration indexes, the unpacked input item and the
// controller-to-datapath command group.
// ----------------------------------------------------------------------------
package rlph_pkg;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_LED  = 2'd1,
        OP_RGB  = 2'd2,
        OP_HSV  = 2'd3
    } rlph_opcode_t;

    localparam logic [0:0] CFG_ON_DUTY = 1'b0;
    localparam logic [0:0] CFG_PERIOD  = 1'b1;

    localparam logic [7:0] ON_DUTY_RESET = 8'd30;
    localparam logic [7:0] PERIOD_RESET  = 8'd255;

    localparam logic [1:0] LED_RED   = 2'd0;
    localparam logic [1:0] LED_GREEN = 2'd1;
    localparam logic [1:0] LED_BLUE  = 2'd2;

    localparam logic [7:0] HUE_SECTOR = 8'd43;
    localparam logic [7:0] REM_SCALE  = 8'd6;
    localparam logic [7:0] FULL_SCALE = 8'd255;

    typedef struct packed {
        logic [1:0] led_index;
        logic       led_on;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } rlph_item_t;

    typedef struct packed {
        logic load_simple;  // apply tick / LED / RGB item, load result
        logic latch_hsv;    // capture HSV operands, region and remainder
        logic mul_step;     // first multiply rank
        logic finish_hsv;   // second multiply rank, write duties, load result
    } rlph_cmd_t;

endpackage

// ===== design/rlph_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlph_ctrl - sequencing controller
// Accepts items, steps HSV items through the two multiply ranks and tracks
// the output register.
// ----------------------------------------------------------------------------
module rlph_ctrl
    import rlph_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  rlph_opcode_t opcode,
    output logic         m_tvalid,
    input  logic         m_tready,
    output rlph_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd.load_simple = accept && (opcode != OP_HSV);
        cmd.latch_hsv   = accept && (opcode == OP_HSV);
        cmd.mul_step    = (state_reg == ST_MUL1);
        cmd.finish_hsv  = (state_reg == ST_MUL2) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.latch_hsv) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                if (cmd.finish_hsv) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_simple || cmd.finish_hsv) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/rlph_dpath.sv =====
// ----------------------------------------------------------------------------
// rlph_dpath - PWM counter, duty registers and HSV arithmetic
// Holds configuration, the counter and duties, the HSV pipeline registers
// and the output payload register.
// ----------------------------------------------------------------------------
module rlph_dpath
    import rlph_pkg::*;
#(
    parameter int COUNT_BITS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [7:0]   cfg_wdata,
    input  rlph_opcode_t opcode,
    input  rlph_item_t   item,
    input  rlph_cmd_t    cmd,
    output logic [31:0]  out_data
);

    logic [7:0]            on_duty_reg, period_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [7:0]            duty_r_reg, duty_g_reg, duty_b_reg;
    logic [7:0]            duty_r_next, duty_g_next, duty_b_next;
    logic [2:0]            pins_next;
    logic [2:0]            pins_reg;

    // HSV pipeline
    logic [2:0]  region_next, region_reg;
    logic [7:0]  rem_next, rem_reg;
    logic [7:0]  sat_reg, val_reg;
    logic [7:0]  p_reg, sx_reg, sy_reg;
    logic [15:0] p_prod, sx_prod, sy_prod, q_prod, t_prod;
    logic [7:0]  q_val, t_val;
    logic [5:0]  diff;
    logic [15:0] rem_full;
    logic [7:0]  led_duty;

    // Region = hue / 43 by a compare chain over the sector bounds.
    always_comb begin
        if (item.hue >= 8'(5 * HUE_SECTOR)) begin
            region_next = 3'd5;
        end else if (item.hue >= 8'(4 * HUE_SECTOR)) begin
            region_next = 3'd4;
        end else if (item.hue >= 8'(3 * HUE_SECTOR)) begin
            region_next = 3'd3;
        end else if (item.hue >= 8'(2 * HUE_SECTOR)) begin
            region_next = 3'd2;
        end else if (item.hue >= HUE_SECTOR) begin
            region_next = 3'd1;
        end else begin
            region_next = 3'd0;
        end
        diff     = 6'(item.hue - 8'(8'(region_next) * HUE_SECTOR));
        rem_full = 16'(diff) * 16'(REM_SCALE);
        rem_next = rem_full[7:0];
    end

    assign p_prod  = 16'(val_reg) * 16'(FULL_SCALE - sat_reg);
    assign sx_prod = 16'(sat_reg) * 16'(rem_reg);
    assign sy_prod = 16'(sat_reg) * 16'(FULL_SCALE - rem_reg);
    assign q_prod  = 16'(val_reg) * 16'(FULL_SCALE - sx_reg);
    assign t_prod  = 16'(val_reg) * 16'(FULL_SCALE - sy_reg);
    assign q_val   = q_prod[15:8];
    assign t_val   = t_prod[15:8];

    assign led_duty = item.led_on ? on_duty_reg : 8'd0;

    always_comb begin
        duty_r_next = duty_r_reg;
        duty_g_next = duty_g_reg;
        duty_b_next = duty_b_reg;
        count_next  = count_reg;
        pins_next   = 3'b000;

        if (cmd.load_simple) begin
            case (opcode)
                OP_TICK: begin
                    pins_next[0] = count_reg < COUNT_BITS'(duty_r_reg);
                    pins_next[1] = count_reg < COUNT_BITS'(duty_g_reg);
                    pins_next[2] = count_reg < COUNT_BITS'(duty_b_reg);
                    if (count_reg >= COUNT_BITS'(period_reg)) begin
                        count_next = '0;
                    end else begin
                        count_next = count_reg + COUNT_BITS'(1);
                    end
                end
                OP_LED: begin
                    case (item.led_index)
                        LED_RED:   duty_r_next = led_duty;
                        LED_GREEN: duty_g_next = led_duty;
                        LED_BLUE:  duty_b_next = led_duty;
                        default: begin
                            // unused channel: change nothing
                        end
                    endcase
                end
                OP_RGB: begin
                    duty_r_next = item.red;
                    duty_g_next = item.green;
                    duty_b_next = item.blue;
                end
                default: begin
                end
            endcase
        end else if (cmd.finish_hsv) begin
            if (sat_reg == 8'd0) begin
                duty_r_next = val_reg;
                duty_g_next = val_reg;
                duty_b_next = val_reg;
            end else begin
                case (region_reg)
                    3'd0: begin
                        duty_r_next = val_reg; duty_g_next = t_val; duty_b_next = p_reg;
                    end
                    3'd1: begin
                        duty_r_next = q_val; duty_g_next = val_reg; duty_b_next = p_reg;
                    end
                    3'd2: begin
                        duty_r_next = p_reg; duty_g_next = val_reg; duty_b_next = t_val;
                    end
                    3'd3: begin
                        duty_r_next = p_reg; duty_g_next = q_val; duty_b_next = val_reg;
                    end
                    3'd4: begin
                        duty_r_next = t_val; duty_g_next = p_reg; duty_b_next = val_reg;
                    end
                    default: begin
                        duty_r_next = val_reg; duty_g_next = p_reg; duty_b_next = q_val;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_duty_reg <= ON_DUTY_RESET;
            period_reg  <= PERIOD_RESET;
            count_reg   <= '0;
            duty_r_reg  <= 8'd0;
            duty_g_reg  <= 8'd0;
            duty_b_reg  <= 8'd0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_ON_DUTY: on_duty_reg <= cfg_wdata;
                    CFG_PERIOD:  period_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            count_reg  <= count_next;
            duty_r_reg <= duty_r_next;
            duty_g_reg <= duty_g_next;
            duty_b_reg <= duty_b_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (cmd.latch_hsv) begin
            region_reg <= region_next;
            rem_reg    <= rem_next;
            sat_reg    <= item.saturation;
            val_reg    <= item.brightness;
        end
        if (cmd.mul_step) begin
            p_reg  <= p_prod[15:8];
            sx_reg <= sx_prod[15:8];
            sy_reg <= sy_prod[15:8];
        end
        if (cmd.load_simple || cmd.finish_hsv) begin
            pins_reg <= pins_next;
        end
    end

    // Duty fields of the result mirror the duty registers after the item.
    assign out_data = {5'b00000, duty_b_reg, duty_g_reg, duty_r_reg, pins_reg};

endmodule

// ===== design/rgb_led_pwm_with_hsv.sv =====
// ----------------------------------------------------------------------------
// rgb_led_pwm_with_hsv - three-channel PWM driver with HSV color loading
// Top level: unpacks stream items, joins controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_ stream; s_tuser carries the item kind (tick,
//   single LED on/off, raw RGB, HSV). Each item yields exactly one result on
//   the m_ stream: the three PWM pin levels (zero unless the item is a tick)
//   and the three duties as they stand after the item.
//   Tick, LED and RGB items: the result is valid the cycle after
//   acceptance and a new item is taken every cycle while the output
//   register drains. HSV items pass the operand/region latch, then the
//   first and the second rank of the 8x8 multiplier chain, the second
//   writing the duties. Configuration goes through cfg_we/cfg_addr/
//   cfg_wdata (0 on_duty, 1 period); the user must write it only while
//   the block is idle, and the block itself does not enforce this.
//   Reset: counter and duties clear to zero, on_duty loads 30, period 255,
//   no result is pending.
//   Stall: while m_tready is low a pending result holds in the output
//   register and s_tready drops; an HSV item already in the multipliers
//   finishes only when the output register is free, and its result holds.
// ----------------------------------------------------------------------------
`include "rgb_led_pwm_with_hsv_macros.svh"

module rgb_led_pwm_with_hsv
    import rlph_pkg::*;
#(
    parameter int COUNT_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,

    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // led_index[1:0], led_on[2], red[10:3], green[18:11], blue[26:19],
    // hue[34:27], saturation[42:35], brightness[50:43], zero fill above
    input  logic [55:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,

    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // pin_red[0], pin_green[1], pin_blue[2], duty_red_now[10:3],
    // duty_green_now[18:11], duty_blue_now[26:19], zero fill above
    output logic [31:0] m_tdata
);

    rlph_opcode_t opcode;
    rlph_item_t   item;
    rlph_cmd_t    cmd;

    // Unpack the item fields from the stream word.
    assign opcode = rlph_opcode_t'(s_tuser);
    assign item   = '{
        led_index:  s_tdata[1:0],
        led_on:     s_tdata[2],
        red:        s_tdata[10:3],
        green:      s_tdata[18:11],
        blue:       s_tdata[26:19],
        hue:        s_tdata[34:27],
        saturation: s_tdata[42:35],
        brightness: s_tdata[50:43]
    };

    rlph_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (opcode),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    rlph_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .opcode    (opcode),
        .item      (item),
        .cmd       (cmd),
        .out_data  (m_tdata)
    );

    // An HSV item blocks the input while it works through the multipliers.
    `RLPH_ASSERT_NEXT(a_hsv_blocks_input, s_tvalid && s_tready && (s_tuser == OP_HSV), !s_tready)

    // A tick, LED or RGB item always has its result ready the following cycle.
    `RLPH_ASSERT_NEXT(a_simple_result_next, s_tvalid && s_tready && (s_tuser != OP_HSV), m_tvalid)

    // RGB items, which are not ticks, never drive the pins high.
    `RLPH_ASSERT_NEXT(a_pins_low_non_tick, s_tvalid && s_tready && (s_tuser == OP_RGB), m_tdata[2:0] == 3'b000)

    // The controller never accepts an item in the same cycle as an HSV multiply or finish step.
    `RLPH_ASSERT_SAME(a_single_load, cmd.load_simple || cmd.latch_hsv, !cmd.finish_hsv && !cmd.mul_step)

endmodule
